// ===== hw/rtl/ohs_pkg.sv =====
// ----------------------------------------------------------------------------
// ohs_pkg
// Shared sizes, codes and types of the open-addressing hash set.
// ----------------------------------------------------------------------------
package ohs_pkg;

  localparam int MAX_SLOTS  = 256;
  localparam int IDX_W      = $clog2(MAX_SLOTS);
  localparam int SLOT_W     = IDX_W + 1;
  localparam int KEY_W      = 64;
  localparam int HASH_W     = 64;
  localparam int VALUE_BITS = 32;
  localparam int CHG_W      = 32;

  localparam logic [SLOT_W-1:0] NIL_SLOT = SLOT_W'(MAX_SLOTS);

  localparam logic [2:0] OP_LOOKUP = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_PUSH   = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_GROW      = 2'd1;
  localparam logic [1:0] ERR_OVERCROWD = 2'd2;

  typedef struct packed {
    logic                  zombie;
    logic [HASH_W-1:0]     hash;
    logic [KEY_W-1:0]      key;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] bucket;
  } mod_res_t;

endpackage

// ===== hw/rtl/ohs_ram.sv =====
// ----------------------------------------------------------------------------
// ohs_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ohs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/ohs_mod.sv =====
// ----------------------------------------------------------------------------
// ohs_mod
// Bit-serial home bucket unit: signed 64-bit hash mod bucket count,
// made non-negative. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module ohs_mod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ohs_pkg::HASH_W-1:0]    dividend,
  input  logic [ohs_pkg::SLOT_W-1:0]    divisor,
  output ohs_pkg::mod_res_t             res
);

  logic [ohs_pkg::HASH_W-1:0]         mag;
  logic [ohs_pkg::SLOT_W-1:0]         rem;
  logic [ohs_pkg::SLOT_W-1:0]         div;
  logic [$clog2(ohs_pkg::HASH_W)-1:0] cnt;
  logic                               neg;
  logic                               busy;
  logic                               done;
  logic [ohs_pkg::SLOT_W:0]           trial;
  logic [ohs_pkg::SLOT_W-1:0]         adj;

  always_comb begin
    trial = {rem, mag[ohs_pkg::HASH_W-1]};
    if (trial >= {1'b0, div}) begin
      trial = trial - {1'b0, div};
    end
    adj = (neg && rem != '0) ? div - rem : rem;
  end

  assign res.done   = done;
  assign res.bucket = adj[ohs_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg  <= dividend[ohs_pkg::HASH_W-1];
        mag  <= dividend[ohs_pkg::HASH_W-1] ? (~dividend) + 1'b1 : dividend;
        rem  <= '0;
        div  <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= trial[ohs_pkg::SLOT_W-1:0];
        mag <= {mag[ohs_pkg::HASH_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/open_addressing_hash_set.sv =====
// ----------------------------------------------------------------------------
// open_addressing_hash_set
// Linear-probing hash set with tombstones and insertion-order rebuilds.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one item: operation, key, value,
// key_hash, is_null. Output channel (out_valid/out_stall) returns one result
// item per input item, in order. cfg_write_en/cfg_write_data load the
// initial capacity, which takes effect at the next clear.
// Steps from the accepting edge to out_valid: the bit-serial home bucket
// unit is started, steps and is picked up; each bucket visited takes a
// registered read of the slot memory, then a check; the output register
// is loaded last. Add and push first pass a load check; remove then
// unlinks the entry from the insertion list, an insert links it in. Clear,
// null items and unused codes go straight to the last state. A rebuild
// copies the insertion list to a staging memory, clears the table and
// reinserts each entry. The next item is taken in the cycle after the result loads.
// in_stall is high whenever an item is in progress; the result sits in an
// output register so the next item is taken while it waits. A stalled
// receiver holds the finished item in the last state until the register
// frees. Reset empties the table (occupied bits in flops, tombstone flag kept
// with each entry in the slot memory, no clearing pass), sets capacity to 16
// and zeroes the live, tombstone and change counts.
// ----------------------------------------------------------------------------
module open_addressing_hash_set (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         operation,
  input  logic [ohs_pkg::KEY_W-1:0]          key,
  input  logic [ohs_pkg::VALUE_BITS-1:0]     value,
  input  logic signed [ohs_pkg::HASH_W-1:0]  key_hash,
  input  logic                               is_null,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               hit,
  output logic [ohs_pkg::KEY_W-1:0]          old_key,
  output logic [ohs_pkg::VALUE_BITS-1:0]     old_value,
  output logic [ohs_pkg::SLOT_W-1:0]         live_total,
  output logic [ohs_pkg::SLOT_W-1:0]         capacity_now,
  output logic [ohs_pkg::CHG_W-1:0]          change_total,
  output logic [1:0]                         error_code,
  input  logic                               cfg_write_en,
  input  logic [ohs_pkg::SLOT_W-1:0]         cfg_write_data
);

  typedef enum logic [17:0] {
    S_IDLE     = 18'b000000000000000001,
    S_GROW     = 18'b000000000000000010,
    S_PR_START = 18'b000000000000000100,
    S_PR_WAIT  = 18'b000000000000001000,
    S_PR_RD    = 18'b000000000000010000,
    S_PR_CHK   = 18'b000000000000100000,
    S_RM_RD    = 18'b000000000001000000,
    S_RM_WR    = 18'b000000000010000000,
    S_LN_A     = 18'b000000000100000000,
    S_LN_B     = 18'b000000001000000000,
    S_RB_WRD   = 18'b000000010000000000,
    S_RB_WWR   = 18'b000000100000000000,
    S_RB_CLR   = 18'b000001000000000000,
    S_RB_IRD   = 18'b000010000000000000,
    S_RB_ILAT  = 18'b000100000000000000,
    S_RB_IWAIT = 18'b001000000000000000,
    S_RB_SCAN  = 18'b010000000000000000,
    S_FIN      = 18'b100000000000000000
  } state_t;

  localparam int SW = ohs_pkg::SLOT_W;
  localparam int IW = ohs_pkg::IDX_W;

  state_t state;

  // item under work
  logic [2:0]                     op_r;
  logic [ohs_pkg::KEY_W-1:0]      key_r;
  logic [ohs_pkg::VALUE_BITS-1:0] val_r;
  logic [ohs_pkg::HASH_W-1:0]     hash_r;

  // pending result
  logic                           res_hit;
  logic [ohs_pkg::KEY_W-1:0]      res_key;
  logic [ohs_pkg::VALUE_BITS-1:0] res_val;
  logic [1:0]                     res_err;

  // table state
  logic [ohs_pkg::MAX_SLOTS-1:0]  occ;
  logic [SW-1:0]                  oldest;
  logic [SW-1:0]                  newest;
  logic [SW-1:0]                  live_cnt;
  logic [SW-1:0]                  zom_cnt;
  logic [SW-1:0]                  cap;
  logic [ohs_pkg::CHG_W-1:0]      chg;
  logic [SW-1:0]                  init_cap;

  // probe and rebuild control
  logic [IW-1:0]                  idx;
  logic [SW-1:0]                  pcnt;
  logic                           retried;
  logic                           rb_active;
  logic [SW:0]                    new_cap;
  logic [SW-1:0]                  cur;
  logic [SW-1:0]                  rb_cnt;
  logic [SW-1:0]                  rb_k;
  ohs_pkg::entry_t                ins;

  // memory ports
  logic                           d_we;
  logic [IW-1:0]                  d_addr;
  ohs_pkg::entry_t                d_wdata;
  ohs_pkg::entry_t                d_rdata;
  logic                           n_we;
  logic [IW-1:0]                  n_addr;
  logic [SW-1:0]                  n_wdata;
  logic [SW-1:0]                  n_rdata;
  logic                           o_we;
  logic [IW-1:0]                  o_addr;
  logic [SW-1:0]                  o_wdata;
  logic [SW-1:0]                  o_rdata;
  logic                           t_we;
  logic [IW-1:0]                  t_addr;
  ohs_pkg::entry_t                t_rdata;

  // home bucket unit
  logic                           m_start;
  logic [ohs_pkg::HASH_W-1:0]     m_hash;
  ohs_pkg::mod_res_t              m_res;

  logic [SW:0]                    grow_t;
  logic                           grow_over;
  logic [SW+1:0]                  load2;
  logic [SW-1:0]                  idx_inc;
  logic [IW-1:0]                  idx_wrap;
  logic                           slot_match;
  logic [SW-1:0]                  clamp_cap;

  ohs_ram #(.WIDTH($bits(ohs_pkg::entry_t)), .DEPTH(ohs_pkg::MAX_SLOTS)) u_data (
    .clk(clk), .we(d_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_rdata)
  );
  ohs_ram #(.WIDTH(SW), .DEPTH(ohs_pkg::MAX_SLOTS)) u_newer (
    .clk(clk), .we(n_we), .addr(n_addr), .wdata(n_wdata), .rdata(n_rdata)
  );
  ohs_ram #(.WIDTH(SW), .DEPTH(ohs_pkg::MAX_SLOTS)) u_older (
    .clk(clk), .we(o_we), .addr(o_addr), .wdata(o_wdata), .rdata(o_rdata)
  );
  // rebuild staging copy of the live entries, oldest first
  ohs_ram #(.WIDTH($bits(ohs_pkg::entry_t)), .DEPTH(ohs_pkg::MAX_SLOTS)) u_tmp (
    .clk(clk), .we(t_we), .addr(t_addr), .wdata(d_rdata), .rdata(t_rdata)
  );

  ohs_mod u_mod (
    .clk(clk), .rst(rst), .start(m_start), .dividend(m_hash), .divisor(cap),
    .res(m_res)
  );

  assign in_stall = (state != S_IDLE);

  always_comb begin
    // same capacity when tombstones dominate, else double
    grow_t    = (zom_cnt > live_cnt) ? {1'b0, cap} : {cap, 1'b0};
    grow_over = grow_t > (SW+1)'(ohs_pkg::MAX_SLOTS);
    load2     = {({1'b0, live_cnt} + {1'b0, zom_cnt}), 1'b0};
    idx_inc   = {1'b0, idx} + 1'b1;
    idx_wrap  = (idx_inc == cap) ? '0 : idx_inc[IW-1:0];
    slot_match = !d_rdata.zombie && d_rdata.hash == hash_r && d_rdata.key == key_r;
    if (init_cap == '0) begin
      clamp_cap = SW'(1);
    end else if (init_cap > SW'(ohs_pkg::MAX_SLOTS)) begin
      clamp_cap = SW'(ohs_pkg::MAX_SLOTS);
    end else begin
      clamp_cap = init_cap;
    end
  end

  // memory port steering
  always_comb begin
    d_we    = 1'b0;
    d_addr  = idx;
    d_wdata = ins;
    n_we    = 1'b0;
    n_addr  = idx;
    n_wdata = ohs_pkg::NIL_SLOT;
    o_we    = 1'b0;
    o_addr  = idx;
    o_wdata = newest;
    t_we    = 1'b0;
    t_addr  = rb_k[IW-1:0];
    m_start = 1'b0;
    m_hash  = hash_r;
    unique case (state)
      S_PR_START: m_start = 1'b1;
      S_PR_CHK: begin
        if (occ[idx] && slot_match) begin
          if (op_r == ohs_pkg::OP_PUSH) begin
            // push over a live match: rewrite the entry with the new value
            d_we    = 1'b1;
            d_wdata = '{zombie: 1'b0, hash: hash_r, key: key_r, value: val_r};
          end else if (op_r == ohs_pkg::OP_REMOVE) begin
            // remove: keep the entry in place, mark it as a tombstone
            d_we           = 1'b1;
            d_wdata        = d_rdata;
            d_wdata.zombie = 1'b1;
          end
        end
      end
      S_RM_WR: begin
        n_addr  = o_rdata[IW-1:0];
        n_wdata = n_rdata;
        n_we    = !o_rdata[SW-1];
        o_addr  = n_rdata[IW-1:0];
        o_wdata = o_rdata;
        o_we    = !n_rdata[SW-1];
      end
      S_LN_A: begin
        d_we = 1'b1;
        n_we = 1'b1;
        o_we = 1'b1;
      end
      S_LN_B: begin
        n_addr  = newest[IW-1:0];
        n_wdata = {1'b0, idx};
        n_we    = !newest[SW-1];
      end
      S_RB_WRD: begin
        d_addr = cur[IW-1:0];
        n_addr = cur[IW-1:0];
      end
      S_RB_WWR: begin
        t_addr = rb_cnt[IW-1:0];
        t_we   = 1'b1;
      end
      S_RB_ILAT: begin
        m_start = 1'b1;
        m_hash  = t_rdata.hash;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      occ       <= '0;
      oldest    <= ohs_pkg::NIL_SLOT;
      newest    <= ohs_pkg::NIL_SLOT;
      live_cnt  <= '0;
      zom_cnt   <= '0;
      cap       <= SW'(16);
      chg       <= '0;
      init_cap  <= SW'(16);
      retried   <= 1'b0;
      rb_active <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        init_cap <= cfg_write_data;
      end
      // drop a taken result; the last state reloads the register itself
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= operation;
            key_r   <= key;
            val_r   <= value;
            hash_r  <= key_hash;
            res_hit <= 1'b0;
            res_key <= '0;
            res_val <= '0;
            res_err <= ohs_pkg::ERR_NONE;
            retried <= 1'b0;
            if (operation == ohs_pkg::OP_CLEAR) begin
              occ      <= '0;
              oldest   <= ohs_pkg::NIL_SLOT;
              newest   <= ohs_pkg::NIL_SLOT;
              live_cnt <= '0;
              zom_cnt  <= '0;
              chg      <= '0;
              cap      <= clamp_cap;
              state    <= S_FIN;
            end else if (operation > ohs_pkg::OP_CLEAR || is_null) begin
              state <= S_FIN;
            end else if (operation == ohs_pkg::OP_ADD || operation == ohs_pkg::OP_PUSH) begin
              state <= S_GROW;
            end else begin
              state <= S_PR_START;
            end
          end
        end

        S_GROW: begin
          if (load2 >= (SW+2)'(cap)) begin
            if (grow_over) begin
              res_err <= ohs_pkg::ERR_GROW;
              state   <= S_FIN;
            end else begin
              new_cap <= grow_t;
              cur     <= oldest;
              rb_cnt  <= '0;
              state   <= S_RB_WRD;
            end
          end else begin
            state <= S_PR_START;
          end
        end

        S_PR_START: begin
          pcnt  <= '0;
          state <= S_PR_WAIT;
        end

        S_PR_WAIT: begin
          if (m_res.done) begin
            idx   <= m_res.bucket;
            state <= S_PR_RD;
          end
        end

        S_PR_RD: begin
          if (pcnt == cap) begin
            // every bucket visited without a free or matching slot
            priority if (op_r == ohs_pkg::OP_LOOKUP) begin
              state <= S_FIN;
            end else if (op_r == ohs_pkg::OP_REMOVE) begin
              res_err <= ohs_pkg::ERR_OVERCROWD;
              state   <= S_FIN;
            end else if (retried || grow_over) begin
              res_err <= ohs_pkg::ERR_GROW;
              state   <= S_FIN;
            end else begin
              retried <= 1'b1;
              if (op_r == ohs_pkg::OP_ADD) begin
                chg <= chg + 1'b1;
              end
              new_cap <= grow_t;
              cur     <= oldest;
              rb_cnt  <= '0;
              state   <= S_RB_WRD;
            end
          end else begin
            state <= S_PR_CHK;
          end
        end

        S_PR_CHK: begin
          if (!occ[idx]) begin
            if (op_r == ohs_pkg::OP_ADD || op_r == ohs_pkg::OP_PUSH) begin
              chg     <= chg + 1'b1;
              ins     <= '{zombie: 1'b0, hash: hash_r, key: key_r, value: val_r};
              res_hit <= (op_r == ohs_pkg::OP_ADD);
              state   <= S_LN_A;
            end else begin
              state <= S_FIN;
            end
          end else if (slot_match) begin
            if (op_r != ohs_pkg::OP_ADD) begin
              res_hit <= 1'b1;
              res_key <= d_rdata.key;
              res_val <= d_rdata.value;
            end
            if (op_r == ohs_pkg::OP_REMOVE) begin
              chg      <= chg + 1'b1;
              zom_cnt  <= zom_cnt + 1'b1;
              state    <= S_RM_RD;
            end else begin
              state <= S_FIN;
            end
          end else begin
            idx   <= idx_wrap;
            pcnt  <= pcnt + 1'b1;
            state <= S_PR_RD;
          end
        end

        S_RM_RD: state <= S_RM_WR;

        S_RM_WR: begin
          // unlink from the insertion list
          if (o_rdata[SW-1]) begin
            oldest <= n_rdata;
          end
          if (n_rdata[SW-1]) begin
            newest <= o_rdata;
          end
          live_cnt <= live_cnt - 1'b1;
          state    <= S_FIN;
        end

        S_LN_A: begin
          occ[idx] <= 1'b1;
          state    <= S_LN_B;
        end

        S_LN_B: begin
          newest <= {1'b0, idx};
          if (oldest[SW-1]) begin
            oldest <= {1'b0, idx};
          end
          live_cnt <= live_cnt + 1'b1;
          if (rb_active) begin
            rb_k  <= rb_k + 1'b1;
            state <= S_RB_IRD;
          end else begin
            state <= S_FIN;
          end
        end

        S_RB_WRD: begin
          state <= cur[SW-1] ? S_RB_CLR : S_RB_WWR;
        end

        S_RB_WWR: begin
          cur    <= n_rdata;
          rb_cnt <= rb_cnt + 1'b1;
          state  <= S_RB_WRD;
        end

        S_RB_CLR: begin
          chg       <= chg + 1'b1;
          occ       <= '0;
          oldest    <= ohs_pkg::NIL_SLOT;
          newest    <= ohs_pkg::NIL_SLOT;
          live_cnt  <= '0;
          zom_cnt   <= '0;
          cap       <= new_cap[SW-1:0];
          rb_k      <= '0;
          rb_active <= 1'b1;
          state     <= S_RB_IRD;
        end

        S_RB_IRD: begin
          if (rb_k == rb_cnt) begin
            rb_active <= 1'b0;
            state     <= S_PR_START;
          end else begin
            state <= S_RB_ILAT;
          end
        end

        S_RB_ILAT: begin
          ins   <= t_rdata;
          state <= S_RB_IWAIT;
        end

        S_RB_IWAIT: begin
          if (m_res.done) begin
            idx   <= m_res.bucket;
            state <= S_RB_SCAN;
          end
        end

        S_RB_SCAN: begin
          // the rebuilt table is at most half full, so a free slot exists
          if (!occ[idx]) begin
            state <= S_LN_A;
          end else begin
            idx <= idx_wrap;
          end
        end

        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            hit          <= res_hit;
            old_key      <= res_key;
            old_value    <= res_val;
            live_total   <= live_cnt;
            capacity_now <= cap;
            change_total <= chg;
            error_code   <= res_err;
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
